// ----- hw/rtl/matrix_vector_transform_4x4_core_assert.svh -----
// Assertion macros for the 4x4 transform core checker
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_CORE_ASSERT_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define MVT_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("mvt port check failed");

// Next-cycle implication, sampled on i_clk, off during reset
`define MVT_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("mvt port check failed");

`endif

// ----- hw/rtl/mvt_pkg.sv -----
// Shared constants, types and reset values for the 4x4 transform core
`timescale 1ns / 1ps

package mvt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int VEC_W      = NUM_ROWS * DATA_W;
    localparam int HI_LSB     = DATA_W - 1 + FRAC_BITS;

    localparam logic [DATA_W-1:0] ONE_FIX = DATA_W'(1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [NUM_ROWS-1:0][DATA_W-1:0]                t_vec;
    typedef logic [NUM_ROWS-1:0][NUM_ROWS-1:0][DATA_W-1:0]  t_mat;
    typedef logic [NUM_ROWS-1:0][NUM_ROWS-1:0][PROD_W-1:0]  t_prod_mat;
    typedef logic [NUM_ROWS-1:0][1:0][PAIR_W-1:0]           t_pair_mat;
    typedef logic [NUM_ROWS-1:0][SUM_W-1:0]                 t_sum_vec;

    // Identity matrix contents of one coefficient register
    function automatic logic [CFG_DATA_W-1:0] reg_reset(input logic [REG_IDX_W-1:0] idx);
        logic [REG_IDX_W-2:0] row;
        logic                 half;
        logic [CFG_DATA_W-1:0] val;
        row  = idx[REG_IDX_W-1:1];
        half = idx[0];
        val  = '0;
        if (row[1] == half) begin
            if (row[0]) begin
                val[CFG_DATA_W-1 -: DATA_W] = ONE_FIX;
            end else begin
                val[DATA_W-1:0] = ONE_FIX;
            end
        end
        return val;
    endfunction

endpackage

// ----- hw/rtl/mvt_coef_regs.sv -----
// Coefficient register bank with identity reset and plain write port
`timescale 1ns / 1ps

module mvt_coef_regs
    import mvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_mat                  o_mat
);

    logic [CFG_DATA_W-1:0] r_coef [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= reg_reset(REG_IDX_W'(i));
            end
        end else if (i_cfg_wr_en && (i_cfg_idx < CFG_IDX_W'(NUM_REGS))) begin
            r_coef[i_cfg_idx[REG_IDX_W-1:0]] <= i_cfg_wdata;
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_ROWS; c++) begin
                o_mat[r][c] = r_coef[r * 2 + (c >> 1)][(c & 1) * DATA_W +: DATA_W];
            end
        end
    end

endmodule

// ----- hw/rtl/mvt_mul_stage.sv -----
// Input register and sixteen registered 32x32 signed products
`timescale 1ns / 1ps

module mvt_mul_stage
    import mvt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_vec      i_vec,
    input  t_mat      i_mat,
    output logic      o_valid,
    output t_prod_mat o_prod
);

    logic      r_in_valid;
    t_vec      r_in_vec;
    logic      r_prod_valid;
    t_prod_mat r_prod;
    t_prod_mat n_prod;

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_ROWS; c++) begin
                n_prod[r][c] = PROD_W'($signed(i_mat[r][c]) * $signed(r_in_vec[c]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prod_valid <= 1'b0;
        end else if (i_en) begin
            r_in_valid   <= i_valid;
            r_prod_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in_vec <= i_vec;
            r_prod   <= n_prod;
        end
    end

    assign o_valid = r_prod_valid;
    assign o_prod  = r_prod;

endmodule

// ----- hw/rtl/mvt_add_tree.sv -----
// Two-level registered adder tree: pair sums, then row sums
`timescale 1ns / 1ps

module mvt_add_tree
    import mvt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_prod_mat i_prod,
    output logic      o_valid,
    output t_sum_vec  o_sum
);

    logic      r_pair_valid;
    t_pair_mat r_pair;
    t_pair_mat n_pair;
    logic      r_sum_valid;
    t_sum_vec  r_sum;
    t_sum_vec  n_sum;

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int k = 0; k < 2; k++) begin
                n_pair[r][k] = PAIR_W'($signed(i_prod[r][2 * k]))
                             + PAIR_W'($signed(i_prod[r][2 * k + 1]));
            end
            n_sum[r] = SUM_W'($signed(r_pair[r][0])) + SUM_W'($signed(r_pair[r][1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_valid <= 1'b0;
            r_sum_valid  <= 1'b0;
        end else if (i_en) begin
            r_pair_valid <= i_valid;
            r_sum_valid  <= r_pair_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pair <= n_pair;
            r_sum  <= n_sum;
        end
    end

    assign o_valid = r_sum_valid;
    assign o_sum   = r_sum;

endmodule

// ----- hw/rtl/mvt_sat_stage.sv -----
// Fraction shift, 32-bit saturation and output register
`timescale 1ns / 1ps

module mvt_sat_stage
    import mvt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_sum_vec i_sum,
    output logic     o_valid,
    output t_vec     o_vec,
    output logic     o_sat
);

    logic r_valid;
    t_vec r_vec;
    logic r_sat;
    t_vec n_vec;
    logic n_sat;

    always_comb begin
        logic [SUM_W-1-HI_LSB:0] hi;
        n_sat = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            hi = i_sum[r][SUM_W-1:HI_LSB];
            if ((&hi) || !(|hi)) begin
                n_vec[r] = i_sum[r][HI_LSB:FRAC_BITS];
            end else begin
                n_vec[r] = i_sum[r][SUM_W-1] ? SAT_MIN : SAT_MAX;
                n_sat    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
            r_sat <= n_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_sat   = r_sat;

endmodule

// ----- hw/rtl/matrix_vector_transform_4x4_core.sv -----
// Top level of the 4x4 matrix times vector transform core
//
// Multiplies each input vector (x, y, z, w; signed Q16.16) by a 4x4 coefficient
// matrix held in eight 64-bit registers, two coefficients per register, column
// pair A,B of row R in register 2R+A/2 (low half column A). Reset loads the
// identity. Each row sum is exact, floored by the fraction bits and clamped to
// 32 bits; tuser flags a clamp. One vector is taken every clock unless the
// master side stalls; a result passes through five register stages (input
// register, multiply, pair add, row add, saturate). Back-pressure on the
// master side freezes all stages at once, so s_tready follows m_tready
// combinationally. Write the coefficients only while the pipeline is empty.
`timescale 1ns / 1ps

module matrix_vector_transform_4x4_core
    import mvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [VEC_W-1:0]      i_s_tdata,   // in_x, in_y, in_z, in_w
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [VEC_W-1:0]      o_m_tdata,   // out_x, out_y, out_z, out_w
    output logic                  o_m_tuser    // saturated
);

    t_mat      w_mat;
    logic      w_en;
    logic      w_prod_valid;
    t_prod_mat w_prod;
    logic      w_sum_valid;
    t_sum_vec  w_sum;
    t_vec      w_out_vec;

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    mvt_coef_regs u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_mat       (w_mat)
    );

    mvt_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_vec   (t_vec'(i_s_tdata)),
        .i_mat   (w_mat),
        .o_valid (w_prod_valid),
        .o_prod  (w_prod)
    );

    mvt_add_tree u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_prod_valid),
        .i_prod  (w_prod),
        .o_valid (w_sum_valid),
        .o_sum   (w_sum)
    );

    mvt_sat_stage u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sum_valid),
        .i_sum   (w_sum),
        .o_valid (o_m_tvalid),
        .o_vec   (w_out_vec),
        .o_sat   (o_m_tuser)
    );

    assign o_m_tdata = VEC_W'(w_out_vec);

endmodule

// ----- hw/rtl/mvt_checker.sv -----
// Port-level assertion checker for the 4x4 transform core, with bind
`timescale 1ns / 1ps
`include "matrix_vector_transform_4x4_core_assert.svh"

module mvt_checker
    import mvt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [VEC_W-1:0]      o_m_tdata,
    input logic                  o_m_tuser
);

    `MVT_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    `MVT_ASSERT_IMP(a_stall_blocks_input, o_m_tvalid && !i_m_tready, !o_s_tready)

    `MVT_ASSERT_IMP(a_sat_has_clamp, o_m_tvalid && o_m_tuser,
        o_m_tdata[31:0] == SAT_MAX || o_m_tdata[31:0] == SAT_MIN ||
        o_m_tdata[63:32] == SAT_MAX || o_m_tdata[63:32] == SAT_MIN ||
        o_m_tdata[95:64] == SAT_MAX || o_m_tdata[95:64] == SAT_MIN ||
        o_m_tdata[127:96] == SAT_MAX || o_m_tdata[127:96] == SAT_MIN)

    `MVT_ASSERT_IMP(a_empty_after_reset, $rose(i_rst_n), !o_m_tvalid)

endmodule

bind matrix_vector_transform_4x4_core mvt_checker u_mvt_checker (.*);

// ----- test/matrix_vector_transform_4x4_core_checker.sv -----
`timescale 1ns / 1ps
// Checker for the 4x4 transform core: tracks coefficient writes, predicts and compares results

module matrix_vector_transform_4x4_core_checker
    import mvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [VEC_W-1:0]      i_s_tdata,   // in_x, in_y, in_z, in_w
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [VEC_W-1:0]      i_m_tdata,   // out_x, out_y, out_z, out_w
    input  logic                  i_m_tuser,   // saturated
    output int                    o_errors,
    output int                    o_pending
);

    localparam int ACC_W     = 66;
    localparam int PRINT_CAP = 40;
    localparam logic signed [ACC_W-1:0] ROW_MAX = 66'sh0_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ROW_MIN = -66'sh0_8000_0000;

    typedef struct packed {
        logic sat;
        t_vec elems;
    } t_vertex;

    logic signed [DATA_W-1:0] coefs [NUM_ROWS][NUM_ROWS];
    t_vertex                  expected_vertices [$];
    string                    lane_tag [NUM_ROWS] = '{"out_x", "out_y", "out_z", "out_w"};

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic load_identity();
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_ROWS; c++) begin
                coefs[r][c] = (r == c) ? DATA_W'(1 << FRAC_BITS) : '0;
            end
        end
    endtask

    // Exact dot product per row, floored by the fraction bits, clamped to 32 bits
    function automatic t_vertex transform_vertex(input t_vec v);
        t_vertex                  res;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  scaled;
        logic signed [PROD_W-1:0] prod;
        logic signed [DATA_W-1:0] elem;
        res.sat = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            acc = '0;
            for (int c = 0; c < NUM_ROWS; c++) begin
                elem = v[c];
                prod = coefs[r][c] * elem;
                acc  = acc + prod;
            end
            scaled = acc >>> FRAC_BITS;
            if (scaled > ROW_MAX) begin
                res.elems[r] = SAT_MAX;
                res.sat      = 1'b1;
            end else if (scaled < ROW_MIN) begin
                res.elems[r] = SAT_MIN;
                res.sat      = 1'b1;
            end else begin
                res.elems[r] = scaled[DATA_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (o_errors < PRINT_CAP) begin
            $display("%0t: %s got %h want %h", $time, what, got, want);
        end
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_vertex got;
        t_vertex want;
        int      row;
        int      col;
        if (!i_rst_n) begin
            load_identity();
            expected_vertices.delete();
        end else begin
            // drop writes to indexes past the last register
            if (i_cfg_wr_en && i_cfg_idx < NUM_REGS) begin
                row = int'(i_cfg_idx) / 2;
                col = 2 * int'(i_cfg_idx[0]);
                coefs[row][col]     = i_cfg_wdata[DATA_W-1:0];
                coefs[row][col + 1] = i_cfg_wdata[CFG_DATA_W-1:DATA_W];
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_vertices.push_back(transform_vertex(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.elems = i_m_tdata;
                got.sat   = i_m_tuser;
                if (expected_vertices.size() == 0) begin
                    report_mismatch("result without a request, out_x", got.elems[0], '0);
                end else begin
                    want = expected_vertices.pop_front();
                    for (int k = 0; k < NUM_ROWS; k++) begin
                        if (got.elems[k] !== want.elems[k]) begin
                            report_mismatch(lane_tag[k], got.elems[k], want.elems[k]);
                        end
                    end
                    if (got.sat !== want.sat) begin
                        report_mismatch("saturated", DATA_W'(got.sat), DATA_W'(want.sat));
                    end
                end
            end
        end
        o_pending = expected_vertices.size();
    end

endmodule

// ----- test/matrix_vector_transform_4x4_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the 4x4 transform core: clock, reset, coefficient phases, vertex stimulus

module matrix_vector_transform_4x4_core_tb;
    import mvt_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RST_CYCLES      = 6;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RAND_PHASES     = 14;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int DRAIN_CYCLES    = 16;
    localparam int ONE_INT         = 1 << FRAC_BITS;

    localparam int REG_ROW0_COLS01 = 0;
    localparam int REG_ROW0_COLS23 = 1;
    localparam int REG_ROW1_COLS01 = 2;
    localparam int REG_ROW1_COLS23 = 3;
    localparam int REG_ROW2_COLS01 = 4;
    localparam int REG_ROW2_COLS23 = 5;
    localparam int REG_ROW3_COLS01 = 6;
    localparam int REG_ROW3_COLS23 = 7;

    typedef logic [CFG_DATA_W-1:0] t_coef_bank [NUM_REGS];
    typedef enum int {MIX_FULL, MIX_SMALL, MIX_EXTREME, MIX_ANY} t_value_mix;
    typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_RARE} t_ready_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [VEC_W-1:0]      i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [VEC_W-1:0]      o_m_tdata;
    logic                  o_m_tuser;

    int check_errors;
    int check_pending;
    int cycle_count = 0;
    int burst_left;
    bit no_gaps;

    matrix_vector_transform_4x4_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    matrix_vector_transform_4x4_core_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .o_errors    (check_errors),
        .o_pending   (check_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("matrix_vector_transform_4x4_core_tb failed");
            $finish;
        end
    end

    // Result side stalls: switch between randomly chosen ready patterns
    initial begin
        t_ready_mode mode;
        int          span;
        i_m_tready = 1'b0;
        mode       = RDY_ALWAYS;
        span       = 0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                mode = t_ready_mode'($urandom_range(0, 3));
                span = $urandom_range(32, 256);
            end
            span--;
            case (mode)
                RDY_ALWAYS: i_m_tready <= 1'b1;
                RDY_HALF:   i_m_tready <= 1'($urandom_range(0, 1));
                RDY_MOSTLY: i_m_tready <= ($urandom_range(0, 7) != 0);
                default:    i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic t_vec make_vec(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                                      input logic [DATA_W-1:0] z, input logic [DATA_W-1:0] w);
        t_vec v;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        v[3] = w;
        return v;
    endfunction

    function automatic t_coef_bank uniform_bank(input logic [DATA_W-1:0] c);
        t_coef_bank bank;
        for (int i = 0; i < NUM_REGS; i++) begin
            bank[i] = {c, c};
        end
        return bank;
    endfunction

    function automatic logic [DATA_W-1:0] rand_value(input t_value_mix mix);
        case (mix)
            MIX_FULL:  return $urandom;
            MIX_SMALL: return DATA_W'(int'($urandom_range(0, 16 * ONE_INT)) - 8 * ONE_INT);
            MIX_EXTREME: begin
                case ($urandom_range(0, 6))
                    0:       return SAT_MAX;
                    1:       return SAT_MIN;
                    2:       return '0;
                    3:       return DATA_W'(1);
                    4:       return '1;
                    5:       return ONE_FIX;
                    default: return -ONE_FIX;
                endcase
            end
            default:   return rand_value(t_value_mix'($urandom_range(0, 2)));
        endcase
    endfunction

    function automatic t_vec rand_vertex();
        logic [DATA_W-1:0] e [NUM_ROWS];
        int                pick;
        for (int i = 0; i < NUM_ROWS; i++) begin
            pick = $urandom_range(0, 7);
            e[i] = rand_value(pick < 4 ? MIX_FULL : (pick < 7 ? MIX_SMALL : MIX_EXTREME));
        end
        // homogeneous points
        if ($urandom_range(0, 3) == 0) begin
            e[3] = ONE_FIX;
        end
        return make_vec(e[0], e[1], e[2], e[3]);
    endfunction

    task automatic send_vertex(input t_vec v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = no_gaps ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (check_pending != 0) @(negedge i_clk);
    endtask

    task automatic write_coefs(input t_coef_bank bank, input logic [NUM_REGS-1:0] mask,
                               input bit stray);
        for (int i = 0; i < NUM_REGS; i++) begin
            if (mask[i]) begin
                i_cfg_wr_en <= 1'b1;
                i_cfg_idx   <= CFG_IDX_W'(i);
                i_cfg_wdata <= bank[i];
                @(negedge i_clk);
            end
        end
        // hit an index past the last register
        if (stray) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_idx   <= CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1));
            i_cfg_wdata <= {$urandom, $urandom};
            @(negedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        t_coef_bank bank;
        t_value_mix mix;
        logic [NUM_REGS-1:0] mask;
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        burst_left  = 0;
        no_gaps     = 1'b0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identity from reset
        send_vertex(make_vec('0, '0, '0, '0));
        send_vertex(make_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        send_vertex(make_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
        send_vertex(make_vec(ONE_FIX, -ONE_FIX, '1, 32'h5555_5555));
        send_vertex(make_vec(32'hAAAA_AAAA, 32'h1234_5678, SAT_MAX, SAT_MIN));
        send_vertex(make_vec('1, '1, '1, '1));
        drain();

        write_coefs(uniform_bank(SAT_MAX), '1, 1'b0);
        send_vertex(make_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        send_vertex(make_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
        send_vertex(make_vec('0, '0, '0, '0));
        send_vertex(make_vec(ONE_FIX, '0, '0, '0));
        drain();

        write_coefs(uniform_bank(SAT_MIN), '1, 1'b1);
        send_vertex(make_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
        send_vertex(make_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        send_vertex(make_vec(ONE_FIX, '0, '0, '0));
        drain();

        // smallest coefficient: floor of tiny negative sums
        write_coefs(uniform_bank(DATA_W'(1)), '1, 1'b0);
        send_vertex(make_vec('1, '1, '1, '1));
        send_vertex(make_vec(DATA_W'(1), DATA_W'(1), DATA_W'(1), DATA_W'(1)));
        send_vertex(make_vec(ONE_FIX, '0, '0, '0));
        drain();

        // clamp high and low on different rows at once
        bank                  = uniform_bank('0);
        bank[REG_ROW0_COLS01] = {SAT_MAX, SAT_MAX};
        bank[REG_ROW0_COLS23] = {SAT_MAX, SAT_MAX};
        bank[REG_ROW1_COLS01] = {SAT_MIN, SAT_MIN};
        bank[REG_ROW1_COLS23] = {SAT_MIN, SAT_MIN};
        bank[REG_ROW2_COLS23] = {32'h0, ONE_FIX};
        bank[REG_ROW3_COLS01] = {ONE_FIX, -ONE_FIX};
        bank[REG_ROW3_COLS23] = {ONE_FIX, 32'h0};
        bank[REG_ROW2_COLS01] = {32'h0, 32'h0};
        write_coefs(bank, '1, 1'b0);
        send_vertex(make_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            mix = t_value_mix'($urandom_range(0, 3));
            for (int i = 0; i < NUM_REGS; i++) begin
                bank[i] = {rand_value(mix), rand_value(mix)};
            end
            mask    = ($urandom_range(0, 3) == 0) ? NUM_REGS'($urandom) : '1;
            no_gaps = (p % 4 == 3);
            write_coefs(bank, mask, $urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_vertex(rand_vertex());
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (check_errors == 0) begin
            $display("matrix_vector_transform_4x4_core_tb passed");
        end else begin
            $display("matrix_vector_transform_4x4_core_tb failed");
        end
        $finish;
    end

endmodule
